// File: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication with next-cycle consequent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/atan2_pkg.sv
`default_nettype none
package atan2_pkg;
    localparam int CoordWidth = 16;
    localparam int MagWidth = CoordWidth;
    localparam int FracBits = 13;
    localparam int CoefBits = 10;
    localparam int AngleWidth = FracBits + 3;
    localparam int ProdWidth = 2 * MagWidth;
    localparam int DenWidth = 2 * MagWidth + CoefBits + 1;
    localparam int NumWidth = ProdWidth + FracBits + CoefBits;
    localparam int QuotWidth = FracBits + 2;
    localparam int DivSteps = QuotWidth;
    localparam int QueueDepth = 4;
    localparam int QueuePtrWidth = 2;

    localparam logic [AngleWidth-1:0] PiQ = AngleWidth'(25736);
    localparam logic [AngleWidth-1:0] HalfPiQ = AngleWidth'(12868);

    typedef enum logic [1:0] {
        KIND_ZERO_X = 2'd0,
        KIND_Y_SMALL = 2'd1,
        KIND_Y_BIG = 2'd2
    } kind_t;

    // classified item handed from front to back
    typedef struct packed {
        kind_t kind;
        logic neg_y;
        logic neg_x;
        logic zero_y;
        logic [MagWidth-1:0] big;
        logic [MagWidth-1:0] lesser;
    } work_t;

    // control state carried alongside a division
    typedef struct packed {
        kind_t kind;
        logic neg_y;
        logic neg_x;
        logic zero_y;
    } tag_t;
endpackage
`default_nettype wire

// File: hw/rtl/atan2_rational_approx_unit.sv
`default_nettype none
// path from an accepted transaction to its result: the front queue,
//   product and divisor stages, 16 divider registers and the output register
// throughput: one transaction per clock cycle while results are taken, set by the pipelined divider
// stalls: an untaken result freezes the back; the 4-entry queue then fills
// reset: rst_n asynchronous low clears queue and pipeline valids; coefficient 287
`include "assert_macros.svh"
module atan2_rational_approx_unit (
    input wire logic clk,
    input wire logic rst_n,
    // slave stream: tdata = y_value[15:0], x_value[31:16]
    input wire logic s_axis_tvalid,
    output logic s_axis_tready,
    input wire logic [31:0] s_axis_tdata,
    // master stream: tdata = angle[15:0]
    output logic m_axis_tvalid,
    input wire logic m_axis_tready,
    output logic [15:0] m_axis_tdata,
    // configuration port
    input wire logic psel,
    input wire logic penable,
    input wire logic pwrite,
    input wire logic [2:0] paddr,
    input wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    localparam logic [2:0] AddrCoef = 3'd0;

    // coefficient register, written on the apb access phase
    logic [atan2_pkg::CoefBits-1:0] coef_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) coef_reg <= atan2_pkg::CoefBits'(287);
        else if (psel && penable && pwrite && paddr == AddrCoef)
            coef_reg <= pwdata[atan2_pkg::CoefBits-1:0];
    end
    assign pready = 1'b1;
    assign prdata = (paddr == AddrCoef) ? 32'(coef_reg) : 32'd0;

    // front: classify and queue
    logic q_valid, q_ready;
    atan2_pkg::work_t q_data;
    atan2_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .y_value(s_axis_tdata[15:0]),
        .x_value(s_axis_tdata[31:16]),
        .q_valid(q_valid),
        .q_ready(q_ready),
        .q_data(q_data)
    );

    // back: products, divider, angle assembly
    atan2_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .coef(coef_reg),
        .q_valid(q_valid),
        .q_ready(q_ready),
        .q_data(q_data),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .angle(m_axis_tdata)
    );

    `ASSERT_ALWAYS(a_pready, pready, "pready must stay high")
    `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result withdrawn")
endmodule
`default_nettype wire

// File: hw/rtl/atan2_front.sv
`default_nettype none
`include "assert_macros.svh"
module atan2_front (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    output logic in_ready,
    input wire logic [atan2_pkg::CoordWidth-1:0] y_value,
    input wire logic [atan2_pkg::CoordWidth-1:0] x_value,
    output logic q_valid,
    input wire logic q_ready,
    output atan2_pkg::work_t q_data
);
    localparam int D = atan2_pkg::QueueDepth;
    localparam int P = atan2_pkg::QueuePtrWidth;

    atan2_pkg::work_t mem [D];
    logic [P-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [P:0] cnt_reg, cnt_next;
    atan2_pkg::work_t cls;
    logic [atan2_pkg::MagWidth-1:0] ay, ax;
    logic push, pop;

    always_comb
    begin
        ay = y_value[atan2_pkg::CoordWidth-1] ? (~y_value + 1'b1) : y_value;
        ax = x_value[atan2_pkg::CoordWidth-1] ? (~x_value + 1'b1) : x_value;
        cls.neg_y = y_value[atan2_pkg::CoordWidth-1];
        cls.neg_x = x_value[atan2_pkg::CoordWidth-1];
        cls.zero_y = (ay == '0);
        if (ax == '0)
        begin
            cls.kind = atan2_pkg::KIND_ZERO_X;
            cls.big = ay;
            cls.lesser = ax;
        end
        else if (ay < ax)
        begin
            cls.kind = atan2_pkg::KIND_Y_SMALL;
            cls.big = ax;
            cls.lesser = ay;
        end
        else
        begin
            cls.kind = atan2_pkg::KIND_Y_BIG;
            cls.big = ay;
            cls.lesser = ax;
        end
    end

    assign in_ready = (cnt_reg != (P+1)'(D));
    assign q_valid = (cnt_reg != '0);
    assign q_data = mem[rd_reg];
    assign push = in_valid && in_ready;
    assign pop = q_valid && q_ready;

    always_comb
    begin
        wr_next = push ? wr_reg + 1'b1 : wr_reg;
        rd_next = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (P+1)'(push) - (P+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= cls;
        end
    end

    `ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= (P+1)'(D), "queue count beyond depth")
    `ASSERT_ALWAYS(a_ptr_match, (cnt_reg[P-1:0] == wr_reg - rd_reg), "queue pointers off")
endmodule
`default_nettype wire

// File: hw/rtl/atan2_back.sv
`default_nettype none
`include "assert_macros.svh"
module atan2_back (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic [atan2_pkg::CoefBits-1:0] coef,
    input wire logic q_valid,
    output logic q_ready,
    input wire atan2_pkg::work_t q_data,
    output logic out_valid,
    input wire logic out_ready,
    output logic [atan2_pkg::AngleWidth-1:0] angle
);
    localparam int N = atan2_pkg::DivSteps;
    localparam int PW = atan2_pkg::ProdWidth;
    localparam int DW = atan2_pkg::DenWidth;
    localparam int NW = atan2_pkg::NumWidth;
    localparam int QW = atan2_pkg::QuotWidth;
    localparam int AW = atan2_pkg::AngleWidth;

    // stall the whole pipe when the output holds an untaken result
    logic adv;
    assign adv = !out_valid || out_ready;
    assign q_ready = adv;

    // stage 1: products
    logic s1_v_reg;
    atan2_pkg::tag_t s1_tag_reg;
    logic [PW-1:0] s1_xy_reg, s1_bb_reg, s1_ss_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s1_v_reg <= 1'b0;
        else if (adv) s1_v_reg <= q_valid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tag_reg <= '{q_data.kind, q_data.neg_y, q_data.neg_x, q_data.zero_y};
            s1_xy_reg <= q_data.big * q_data.lesser;
            s1_bb_reg <= q_data.big * q_data.big;
            s1_ss_reg <= q_data.lesser * q_data.lesser;
        end
    end

    // stage 2: divisor
    logic s2_v_reg;
    atan2_pkg::tag_t s2_tag_reg;
    logic [PW-1:0] s2_xy_reg;
    logic [DW-1:0] s2_den_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s2_v_reg <= 1'b0;
        else if (adv) s2_v_reg <= s1_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_tag_reg <= s1_tag_reg;
            s2_xy_reg <= s1_xy_reg;
            s2_den_reg <= {1'b0, s1_bb_reg, atan2_pkg::CoefBits'(0)}
                + DW'(s1_ss_reg * coef);
        end
    end

    // restoring divider, one quotient bit per stage; quotient below 2^QW,
    // so the divisor is tried at shifts QW-1 down to 0
    logic [N:0] dv_v_reg;
    atan2_pkg::tag_t dv_tag_reg [N+1];
    logic [DW-1:0] dv_den_reg [N+1];
    logic [NW-1:0] dv_rem_reg [N+1];
    logic [QW-1:0] dv_q_reg [N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) dv_v_reg <= '0;
        else if (adv) dv_v_reg <= {dv_v_reg[N-1:0], s2_v_reg};
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_tag_reg[0] <= s2_tag_reg;
            dv_den_reg[0] <= s2_den_reg;
            dv_rem_reg[0] <= {s2_xy_reg, (NW-PW)'(0)};
            dv_q_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_div
        localparam int Sh = QW - 1 - i;
        logic [NW+DW-1:0] trial;
        logic take;
        assign trial = {(DW)'(0), dv_rem_reg[i]} - ({(NW)'(0), dv_den_reg[i]} << Sh);
        assign take = !trial[NW+DW-1];
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_tag_reg[i+1] <= dv_tag_reg[i];
                dv_den_reg[i+1] <= dv_den_reg[i];
                dv_rem_reg[i+1] <= take ? trial[NW-1:0] : dv_rem_reg[i];
                dv_q_reg[i+1] <= {dv_q_reg[i][QW-2:0], take};
            end
        end
    end

    // final assembly
    atan2_pkg::tag_t t;
    logic [AW-1:0] q, sq, res;
    always_comb
    begin
        t = dv_tag_reg[N];
        q = AW'(dv_q_reg[N]);
        sq = (t.neg_x != t.neg_y) ? (~q + 1'b1) : q;
        res = '0;
        case (t.kind)
            atan2_pkg::KIND_ZERO_X:
            begin
                if (t.zero_y) res = '0;
                else if (t.neg_y) res = ~atan2_pkg::HalfPiQ + 1'b1;
                else res = atan2_pkg::HalfPiQ;
            end
            atan2_pkg::KIND_Y_SMALL:
            begin
                if (!t.neg_x) res = sq;
                else if (t.neg_y) res = sq - atan2_pkg::PiQ;
                else res = sq + atan2_pkg::PiQ;
            end
            default:
            begin
                res = atan2_pkg::HalfPiQ - sq;
                if (t.neg_y) res = res - atan2_pkg::PiQ;
            end
        endcase
    end

    logic out_v_reg;
    logic [AW-1:0] angle_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_v_reg <= 1'b0;
        else if (adv) out_v_reg <= dv_v_reg[N];
    end
    always_ff @(posedge clk)
    begin
        if (adv) angle_reg <= res;
    end
    assign out_valid = out_v_reg;
    assign angle = angle_reg;

    `ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(angle), "result dropped")
    `ASSERT_ALWAYS(a_div_den, !(dv_v_reg[N] && dv_tag_reg[N].kind != atan2_pkg::KIND_ZERO_X && dv_den_reg[N] == '0), "zero divisor")
    `ASSERT_ALWAYS(a_ready, q_ready == (!out_valid || out_ready), "back accepts while stalled")
endmodule
`default_nettype wire
